// ===== sv/kruskal_grid_maze_carver_macros.svh =====
// Assertion macros used by the checker file.
`ifndef KRUSKAL_GRID_MAZE_CARVER_MACROS_SVH
`define KRUSKAL_GRID_MAZE_CARVER_MACROS_SVH
// An implication checked at every clock edge outside reset.
`define KGM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// A property checked on the clock edge after the antecedent.
`define KGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/kgm_pkg.sv =====
// ------------------------------------------------------------------------
// kgm_pkg
// Types and constants of the grid maze carver.
// ------------------------------------------------------------------------
package kgm_pkg;
    localparam int MAX_SIDE_DEF   = 63;
    localparam int CELL_DEPTH_DEF = 4096;
    localparam int SIDE_W         = 6;
    localparam int IDX_W          = 12;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd21;

    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_WALL   = 2'd1,
        FN_READ   = 2'd2,
        FN_FINISH = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIV,
        ST_CHKA,
        ST_CHKB,
        ST_WALKA,
        ST_WALKB,
        ST_JOIN,
        ST_READ,
        ST_FIN,
        ST_OUT,
        ST_CLR
    } t_state;

    localparam logic [0:0] REG_GRID_SIDE = 1'b0;
endpackage

// ===== sv/kruskal_grid_maze_carver.sv =====
// ------------------------------------------------------------------------
// Kruskal grid maze carver
// Carves a maze on a square grid with a union-find over the cells.
// ------------------------------------------------------------------------
// Channel  | Direction | Handshake            | Payload
// input    | in        | i_valid / o_stall    | i_func, i_cell_index
// result   | out       | o_valid / i_stall    | o_wall_opened, o_cell_is_wall
// config   | in        | APB write, pready=1  | grid_side at address 0
//
// A start item sweeps the cell and parent memories one address a cycle
// in the fill. A try-wall item runs a restoring divider (one quotient bit
// a cycle for IDX_W bits, then a step that picks the neighbours), then reads
// each neighbour and walks each parent chain link by link, all through the
// shared memory read address. Reset is synchronous and active low; after
// reset a clearing pass writes every cell as a wall, one address a cycle,
// and the input is stalled until it is done. One item is in flight at a
// time: o_stall is high from acceptance until the result item has been
// taken, and a stalled result simply holds.
// ------------------------------------------------------------------------
module kruskal_grid_maze_carver #(
    parameter int MAX_SIDE   = kgm_pkg::MAX_SIDE_DEF,
    parameter int CELL_DEPTH = kgm_pkg::CELL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [kgm_pkg::IDX_W-1:0] i_cell_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_wall_opened,
    output logic        o_cell_is_wall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(CELL_DEPTH);
    localparam int IW = kgm_pkg::IDX_W;
    // Wide enough to hold CELL_DEPTH and any product of two sides.
    localparam int WW = (AW + 1 > 2 * IW) ? AW + 1 : 2 * IW;
    localparam logic [WW-1:0] DEPTH_W = WW'(CELL_DEPTH);
    localparam logic [WW-1:0] MAXS_W  = WW'(MAX_SIDE);
    localparam int CW = $clog2(IW + 1);

    kgm_pkg::t_state r_state, n_state;

    logic [kgm_pkg::SIDE_W-1:0] r_side;
    logic [WW-1:0] r_idx;
    logic [WW-1:0] r_s, r_area;
    // Fill / walk cursor and divider state.
    logic [WW-1:0] r_cnt, n_cnt;
    logic [WW-1:0] r_row, r_col, n_row, n_col;
    logic [WW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_bits, n_bits;
    logic [WW-1:0] r_a, r_b, n_a, n_b;
    logic [WW-1:0] r_ra, n_ra;
    logic [WW:0]   r_links, n_links;
    logic          r_phase, n_phase;
    logic          r_opened, n_opened, r_iswall, n_iswall;

    // Memories: one read and one write port each.
    logic          cell_mem [CELL_DEPTH];
    logic [IW-1:0] par_mem  [CELL_DEPTH];
    logic          r_cell_q;
    logic [IW-1:0] r_par_q;
    logic [AW-1:0] rd_addr, wr_addr, pw_addr;
    logic          cw_en, cw_val, pw_en;
    logic [IW-1:0] pw_val;

    assign pready = 1'b1;
    assign prdata = (paddr == kgm_pkg::REG_GRID_SIDE) ? 32'(r_side) : 32'd0;
    assign o_stall = (r_state != kgm_pkg::ST_IDLE);
    assign o_valid = (r_state == kgm_pkg::ST_OUT);
    assign o_wall_opened  = r_opened;
    assign o_cell_is_wall = r_iswall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= kgm_pkg::SIDE_RESET;
        end else if (psel && penable && pwrite && paddr == kgm_pkg::REG_GRID_SIDE) begin
            r_side <= pwdata[kgm_pkg::SIDE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            cell_mem[wr_addr] <= cw_val;
        end
        if (pw_en) begin
            par_mem[pw_addr] <= pw_val;
        end
        r_cell_q <= cell_mem[rd_addr];
        r_par_q  <= par_mem[rd_addr];
    end

    // Effective side and area from the register.
    logic [WW-1:0] side_e, area_e, sq;
    always_comb begin
        side_e = WW'(r_side);
        if (side_e < WW'(3)) side_e = WW'(3);
        if (side_e > MAXS_W) side_e = MAXS_W;
        sq = side_e * side_e;
        area_e = (sq > DEPTH_W) ? DEPTH_W : sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kgm_pkg::ST_CLR;
            r_opened <= 1'b0;
            r_iswall <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_opened <= n_opened;
            r_iswall <= n_iswall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kgm_pkg::ST_IDLE && i_valid) begin
            r_idx  <= WW'(i_cell_index);
            r_s    <= side_e;
            r_area <= area_e;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_row <= n_row; r_col <= n_col;
        r_rem <= n_rem; r_bits <= n_bits;
        r_a <= n_a; r_b <= n_b; r_ra <= n_ra;
        r_links <= n_links; r_phase <= n_phase;
    end

    // Cell is open when stored as open.
    logic        cell_open;
    logic [WW:0] trial;
    logic [WW-1:0] fpar;
    assign cell_open = !r_cell_q;
    assign trial = {r_rem, r_cnt[WW-1]} - {1'b0, r_s};
    assign fpar  = WW'(r_par_q);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_row = r_row; n_col = r_col;
        n_rem = r_rem; n_bits = r_bits;
        n_a = r_a; n_b = r_b; n_ra = r_ra;
        n_links = r_links; n_phase = r_phase;
        n_opened = r_opened; n_iswall = r_iswall;
        rd_addr = r_idx[AW-1:0];
        wr_addr = r_cnt[AW-1:0];
        pw_addr = r_cnt[AW-1:0];
        cw_en = 1'b0; cw_val = 1'b1; pw_en = 1'b0; pw_val = r_cnt[IW-1:0];
        unique case (r_state)
            kgm_pkg::ST_CLR: begin
                // Every cell starts as a wall; one address is written a cycle.
                cw_en = 1'b1;
                if (r_cnt == DEPTH_W - WW'(1)) begin
                    n_cnt = '0;
                    n_state = kgm_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + WW'(1);
                end
            end
            kgm_pkg::ST_IDLE: begin
                n_opened = 1'b0; n_iswall = 1'b0;
                if (i_valid) begin
                    n_cnt = '0; n_row = '0; n_col = '0;
                    unique case (kgm_pkg::t_func'(i_func))
                        kgm_pkg::FN_START:  n_state = kgm_pkg::ST_FILL;
                        kgm_pkg::FN_WALL: begin
                            n_state = kgm_pkg::ST_DIV;
                            n_cnt  = WW'(i_cell_index) << (WW - IW);
                            n_rem  = '0;
                            n_bits = CW'(IW);
                        end
                        kgm_pkg::FN_READ:   n_state = kgm_pkg::ST_READ;
                        kgm_pkg::FN_FINISH: n_state = kgm_pkg::ST_FIN;
                        default: n_state = kgm_pkg::ST_IDLE;
                    endcase
                end
            end
            kgm_pkg::ST_FILL: begin
                if (r_cnt >= r_area) begin
                    n_state = kgm_pkg::ST_OUT;
                end else begin
                    cw_en = 1'b1; pw_en = 1'b1;
                    cw_val = !(r_row[0] && r_col[0]);
                    n_cnt = r_cnt + WW'(1);
                    if (r_col == r_s - WW'(1)) begin
                        n_col = '0; n_row = r_row + WW'(1);
                    end else begin
                        n_col = r_col + WW'(1);
                    end
                end
            end
            kgm_pkg::ST_DIV: begin
                // Restoring division of the index by the side, a bit a cycle.
                if (r_bits == '0) begin
                    n_row = r_row; n_col = r_rem;
                    n_phase = 1'b0;
                    if (r_idx >= r_area) begin
                        n_state = kgm_pkg::ST_OUT;
                    end else if (r_rem >= WW'(1) && r_rem <= r_s - WW'(2)) begin
                        n_a = r_idx - WW'(1); n_b = r_idx + WW'(1);
                        n_state = kgm_pkg::ST_CHKA;
                    end else begin
                        n_phase = 1'b1;
                        n_a = r_idx - r_s; n_b = r_idx + r_s;
                        n_state = (r_row >= WW'(1) && r_row <= r_s - WW'(2)) ?
                            kgm_pkg::ST_CHKA : kgm_pkg::ST_OUT;
                    end
                    n_cnt = '0;
                end else begin
                    n_cnt  = r_cnt << 1;
                    n_bits = r_bits - CW'(1);
                    if (!trial[WW]) begin
                        n_rem = trial[WW-1:0]; n_row = {r_row[WW-2:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[WW-2:0], r_cnt[WW-1]};
                        n_row = {r_row[WW-2:0], 1'b0};
                    end
                end
            end
            kgm_pkg::ST_CHKA: begin
                // Issue a read of a, then of b; cnt steps the sub-phase.
                rd_addr = (r_cnt == '0) ? r_a[AW-1:0] : r_b[AW-1:0];
                if (r_cnt == WW'(1)) begin
                    if (r_a < DEPTH_W && cell_open) begin
                        n_state = kgm_pkg::ST_CHKB;
                    end else begin
                        n_state = kgm_pkg::ST_OUT; n_cnt = '0;
                    end
                end else begin
                    n_cnt = WW'(1);
                end
                if (r_cnt == WW'(1) && !(r_a < DEPTH_W && cell_open) && !r_phase &&
                    r_row >= WW'(1) && r_row <= r_s - WW'(2)) begin
                    n_phase = 1'b1; n_cnt = '0;
                    n_a = r_idx - r_s; n_b = r_idx + r_s;
                    n_state = kgm_pkg::ST_CHKA;
                end
            end
            kgm_pkg::ST_CHKB: begin
                rd_addr = r_a[AW-1:0];
                if (r_b < DEPTH_W && cell_open) begin
                    n_state = kgm_pkg::ST_WALKA; n_links = '0; n_cnt = '0;
                end else if (!r_phase && r_row >= WW'(1) && r_row <= r_s - WW'(2)) begin
                    n_phase = 1'b1; n_cnt = '0;
                    n_a = r_idx - r_s; n_b = r_idx + r_s;
                    n_state = kgm_pkg::ST_CHKA;
                end else begin
                    n_state = kgm_pkg::ST_OUT;
                end
            end
            kgm_pkg::ST_WALKA: begin
                // r_par_q holds parent of r_a (read issued last cycle).
                rd_addr = r_a[AW-1:0];
                if (r_cnt == '0) begin
                    n_cnt = WW'(1);
                end else if (fpar == r_a || fpar >= DEPTH_W ||
                             r_links == (WW+1)'(CELL_DEPTH)) begin
                    n_ra = r_a; n_links = '0; n_cnt = '0;
                    n_state = kgm_pkg::ST_WALKB;
                end else begin
                    n_a = fpar; rd_addr = fpar[AW-1:0];
                    n_links = r_links + (WW+1)'(1);
                end
            end
            kgm_pkg::ST_WALKB: begin
                rd_addr = r_b[AW-1:0];
                if (r_cnt == '0) begin
                    n_cnt = WW'(1);
                end else if (fpar == r_b || fpar >= DEPTH_W ||
                             r_links == (WW+1)'(CELL_DEPTH)) begin
                    n_state = kgm_pkg::ST_JOIN;
                end else begin
                    n_b = fpar; rd_addr = fpar[AW-1:0];
                    n_links = r_links + (WW+1)'(1);
                end
            end
            kgm_pkg::ST_JOIN: begin
                if (r_ra != r_b) begin
                    cw_en = 1'b1; cw_val = 1'b0; wr_addr = r_idx[AW-1:0];
                    pw_en = 1'b1; pw_addr = r_b[AW-1:0]; pw_val = r_ra[IW-1:0];
                    n_opened = 1'b1;
                end
                n_state = kgm_pkg::ST_OUT;
            end
            kgm_pkg::ST_READ: begin
                rd_addr = r_idx[AW-1:0];
                if (r_cnt == '0) begin
                    n_cnt = WW'(1);
                end else begin
                    n_iswall = (r_idx < r_area) ? !cell_open : 1'b1;
                    n_state = kgm_pkg::ST_OUT;
                end
            end
            kgm_pkg::ST_FIN: begin
                // Entrance then exit, one write each.
                if (r_cnt == '0) begin
                    n_a = r_s - WW'(2);
                    n_b = r_s * r_s - r_s + WW'(1);
                    n_cnt = WW'(1);
                end else if (r_cnt == WW'(1)) begin
                    cw_en = r_a < DEPTH_W; cw_val = 1'b0; wr_addr = r_a[AW-1:0];
                    n_cnt = WW'(2);
                end else begin
                    cw_en = r_b < DEPTH_W; cw_val = 1'b0; wr_addr = r_b[AW-1:0];
                    n_state = kgm_pkg::ST_OUT;
                end
            end
            kgm_pkg::ST_OUT: begin
                if (!i_stall) n_state = kgm_pkg::ST_IDLE;
            end
            default: n_state = kgm_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== sv/kgm_checker.sv =====
// ------------------------------------------------------------------------
// kgm_checker
// Port-level checks of the grid maze carver.
// ------------------------------------------------------------------------
`include "kruskal_grid_maze_carver_macros.svh"
module kgm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_wall_opened,
    input logic o_cell_is_wall
);
    // A result is never shown while the block is still free to take an item.
    `KGM_ASSERT_IMPL(a_busy_out, i_clk, i_rst_n, o_valid, o_stall, "result while ready")
    // An accepted item makes the block busy in the next cycle.
    `KGM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "no busy")
    // Only one result flag can be set.
    `KGM_ASSERT_IMPL(a_flags, i_clk, i_rst_n, o_valid, !(o_wall_opened && o_cell_is_wall),
        "both flags")
    // A stalled result holds.
    `KGM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
endmodule

bind kruskal_grid_maze_carver kgm_checker u_kgm_checker (.*);

// ===== test/kruskal_grid_maze_carver_tb.sv =====
// ----------------------------------------------------------------------------
// Grid maze carver testbench
// Drives start, try-wall, read and finish items through the valid/stall
// channel at several grid sides, mirrors the grid and its union-find in a
// local predictor, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
module kruskal_grid_maze_carver_tb;
    import kgm_pkg::*;

    localparam int DEPTH       = CELL_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        t_func             op;
        logic [IDX_W-1:0]  idx;
    } t_carve_item;

    typedef struct {
        logic opened;
        logic is_wall;
    } t_carve_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_func = 2'd0;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_wall_opened;
    logic              o_cell_is_wall;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [0:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    kruskal_grid_maze_carver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_cell_index   (i_cell_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_wall_opened  (o_wall_opened),
        .o_cell_is_wall (o_cell_is_wall),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Items waiting to be driven, and results the grid mirror has promised.
    t_carve_item   pending_items[$];
    t_carve_result promised_results[$];

    // Local mirror of the carver: side register, open/wall map, set links.
    logic [SIDE_W-1:0] side_reg = SIDE_RESET;
    bit                wall_map [DEPTH];
    logic [IDX_W-1:0]  set_link [DEPTH];

    int mismatches  = 0;
    int items_sent  = 0;
    int walls_carved = 0;
    int results_seen = 0;
    int cycle_count = 0;

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            wall_map[i] = 1'b1;
            set_link[i] = '0;
        end
    end

    task automatic report(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic int side_in_use();
        int s;
        s = side_reg;
        if (s < 3) s = 3;
        if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
        return s;
    endfunction

    function automatic int area_in_use(input int s);
        return (s * s > DEPTH) ? DEPTH : s * s;
    endfunction

    function automatic int set_root(input int c);
        int p;
        for (int n = 0; n < DEPTH; n++) begin
            p = set_link[c];
            if (p == c) break;
            c = p;
        end
        return c;
    endfunction

    function automatic bit cell_open(input int c);
        return c < DEPTH && wall_map[c] == 1'b0;
    endfunction

    // Applies one item to the grid mirror and returns the result it causes.
    function automatic t_carve_result carve_step(input t_carve_item it);
        t_carve_result res;
        int s, area, idx, r, c, a, b, ra, rb, entry, exit_cell;
        bit found;
        res = '{opened: 1'b0, is_wall: 1'b0};
        s = side_in_use();
        area = area_in_use(s);
        idx = it.idx;
        found = 1'b0;
        a = 0;
        b = 0;
        case (it.op)
            FN_START: begin
                for (int i = 0; i < area; i++) begin
                    wall_map[i] = !(((i / s) % 2 == 1) && ((i % s) % 2 == 1));
                    set_link[i] = i[IDX_W-1:0];
                end
            end
            FN_WALL: begin
                if (idx < area) begin
                    r = idx / s;
                    c = idx % s;
                    // Horizontal neighbours take priority over vertical ones.
                    if (c >= 1 && c <= s - 2 && cell_open(idx - 1) && cell_open(idx + 1)) begin
                        a = idx - 1; b = idx + 1; found = 1'b1;
                    end else if (r >= 1 && r <= s - 2 && cell_open(idx - s)
                                 && cell_open(idx + s)) begin
                        a = idx - s; b = idx + s; found = 1'b1;
                    end
                    if (found) begin
                        ra = set_root(a);
                        rb = set_root(b);
                        if (ra != rb) begin
                            wall_map[idx] = 1'b0;
                            set_link[rb] = ra[IDX_W-1:0];
                            res.opened = 1'b1;
                        end
                    end
                end
            end
            FN_READ: begin
                res.is_wall = (idx < area) ? wall_map[idx] : 1'b1;
            end
            default: begin
                entry = s - 2;
                exit_cell = s * s - s + 1;
                if (entry < DEPTH) wall_map[entry] = 1'b0;
                if (exit_cell < DEPTH) wall_map[exit_cell] = 1'b0;
            end
        endcase
        return res;
    endfunction

    // Sender: bursts of back-to-back items separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_carve_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_func <= it.op;
                i_cell_index <= it.idx;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches between calm, light and heavy stretches.
    int stall_mode = 0;
    int stall_span = 0;

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(5, 40);
            stall_mode = $urandom_range(0, 2);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Monitor: predict on each accepted item, check each accepted result item.
    always @(posedge i_clk) begin
        t_carve_item   acc;
        t_carve_result want;
        cycle_count++;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                acc.op = t_func'(i_func);
                acc.idx = i_cell_index;
                want = carve_step(acc);
                promised_results.push_back(want);
                items_sent++;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (promised_results.size() == 0) begin
                    report("result item with nothing expected");
                end else begin
                    want = promised_results.pop_front();
                    if (o_wall_opened !== want.opened)
                        report($sformatf("wall_opened %b, expected %b",
                                         o_wall_opened, want.opened));
                    if (o_cell_is_wall !== want.is_wall)
                        report($sformatf("cell_is_wall %b, expected %b",
                                         o_cell_is_wall, want.is_wall));
                    if (want.opened) walls_carved++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Register write over the APB port: a setup phase, then an access phase.
    task automatic write_side(input int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_GRID_SIDE;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        side_reg = value[SIDE_W-1:0];
    endtask

    task automatic push_item(input t_func op, input int idx);
        t_carve_item it;
        it.op = op;
        it.idx = idx[IDX_W-1:0];
        pending_items.push_back(it);
    endtask

    // Waits until every item has gone in and every result item has come out.
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || promised_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One carving run: a start, the walls in shuffled order with a little
    // noise, reads of the grid, the finish, and reads again.
    task automatic carve_phase(input int side_value, input int wall_budget);
        int s, area, pick, tmp;
        int walls[$];
        s = (side_value < 3) ? 3 : (side_value > MAX_SIDE_DEF ? MAX_SIDE_DEF : side_value);
        area = area_in_use(s);
        write_side(side_value);
        push_item(FN_START, $urandom_range(0, 4095));
        for (int r = 1; r <= s - 2; r++)
            for (int c = 1; c <= s - 2; c++)
                if ((r + c) % 2 == 1) walls.push_back(r * s + c);
        for (int i = walls.size() - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = walls[i];
            walls[i] = walls[pick];
            walls[pick] = tmp;
        end
        for (int i = 0; i < walls.size() && i < wall_budget; i++) begin
            push_item(FN_WALL, walls[i]);
            case ($urandom_range(0, 9))
                0: push_item(FN_WALL, walls[$urandom_range(0, i)]);   // retry a tried wall
                1: push_item(FN_WALL, $urandom_range(0, area - 1));
                2: push_item(FN_WALL, $urandom_range(0, 4095));
                3: push_item(FN_READ, $urandom_range(0, area - 1));
                default: ;
            endcase
        end
        for (int i = 0; i < 8; i++) push_item(FN_READ, $urandom_range(0, area - 1));
        push_item(FN_READ, $urandom_range(area, 4095));
        push_item(FN_FINISH, $urandom_range(0, 4095));
        push_item(FN_READ, s - 2);
        push_item(FN_READ, s * s - s + 1);
        for (int i = 0; i < 4; i++) push_item(FN_READ, $urandom_range(0, area - 1));
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any start every cell is a wall and nothing can be carved.
        push_item(FN_WALL, 22);
        push_item(FN_WALL, 0);
        push_item(FN_WALL, 4095);
        push_item(FN_READ, 0);
        push_item(FN_READ, 22);
        push_item(FN_READ, 4095);
        wait_drained();

        // The reset side first, then the extremes, out-of-range and even sides.
        carve_phase(21, 30);
        carve_phase(3, 10);
        carve_phase(63, 40);
        carve_phase(2, 10);
        carve_phase(0, 10);
        carve_phase(8, 30);
        carve_phase(5, 20);
        carve_phase(11, 60);
        carve_phase(15, 60);
        carve_phase(31, 40);
        carve_phase(2 * $urandom_range(1, 31) + 1, 40);
        carve_phase(63, 30);

        repeat (50) @(negedge i_clk);
        $display("Ran %0d items across twelve grid sides, %0d result items checked.",
                 items_sent, results_seen);
        $display("Walls carved: %0d; mismatches: %0d.", walls_carved, mismatches);
        if (mismatches == 0 && promised_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/kgm_pkg.sv
sv/kruskal_grid_maze_carver.sv
sv/kgm_checker.sv
test/kruskal_grid_maze_carver_tb.sv
